// File: hw/rtl/occ_pkg.sv
// Shared types and constants for the occupancy calculator.
// Used by the top level; depends on nothing.
`timescale 1ns / 1ps
package occ_pkg;

   // Configuration register indexes.
   typedef enum logic [2:0] {
      CSR_WAVEFRONT_SIZE   = 3'd0,
      CSR_MAX_WAVES        = 3'd1,
      CSR_MAX_GROUPS       = 3'd2,
      CSR_REG_GRAN_MODE    = 3'd3,
      CSR_REG_ALLOC_SIZE   = 3'd4,
      CSR_REG_FILE_SIZE    = 3'd5,
      CSR_LMEM_ALLOC_SIZE  = 3'd6,
      CSR_LMEM_TOTAL       = 3'd7
   } csr_index_type;

   localparam int CSR_DATA_W = 21;
   localparam int ITEMS_W    = 14;
   localparam int REGS_W     = 9;
   localparam int LOCAL_W    = 21;
   localparam int GROUPS_W   = 7;
   localparam int WPG_W      = 14;
   localparam int WPU_W      = 13;

   // First divider row: wave count and three remainders for rounding.
   localparam int P2_LANES = 4;
   localparam int P2_NW    = 23;
   localparam int P2_DW    = 17;
   localparam int P2_QW    = 23;
   localparam int L2_WAVES = 0;
   localparam int L2_PW    = 1;
   localparam int L2_PI    = 2;
   localparam int L2_LOCAL = 3;

   // Second divider row: the three limits, each clipped to a 7-bit quotient.
   localparam int P4_LANES = 3;
   localparam int P4_NW    = 21;
   localparam int P4_DW    = 32;
   localparam int P4_QW    = 7;
   localparam int L4_WAVE  = 0;
   localparam int L4_REG   = 1;
   localparam int L4_LMEM  = 2;

   typedef struct packed {
      logic [16:0] pw;
      logic [22:0] pi;
      logic [20:0] local_b;
      logic        wz;
   } p2_side_type;

   typedef struct packed {
      logic [WPG_W-1:0]    waves;
      logic [P4_LANES-1:0] use_lim;
   } p4_side_type;

endpackage

// File: hw/rtl/occ_div_cell.sv
// One restoring division step for several lanes, registered.
// Standalone; instantiated in a row by occ_div_chain.
`timescale 1ns / 1ps
module occ_div_cell #(
   parameter int LANES = 1,
   parameter int NW    = 8,
   parameter int DW    = 8,
   parameter int QW    = 8,
   parameter int SW    = 1,
   parameter int SHIFT = 0
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  logic                          in_valid,
   input  logic [LANES-1:0][NW-1:0]      in_rem,
   input  logic [LANES-1:0][DW-1:0]      in_den,
   input  logic [LANES-1:0][QW-1:0]      in_quo,
   input  logic [SW-1:0]                 in_side,
   output logic                          out_valid,
   output logic [LANES-1:0][NW-1:0]      out_rem,
   output logic [LANES-1:0][DW-1:0]      out_den,
   output logic [LANES-1:0][QW-1:0]      out_quo,
   output logic [SW-1:0]                 out_side
);

   localparam int CW = NW + DW;

   logic                     valid_ff;
   logic [LANES-1:0][NW-1:0] rem_ff, rem_in;
   logic [LANES-1:0][DW-1:0] den_ff;
   logic [LANES-1:0][QW-1:0] quo_ff, quo_in;
   logic [SW-1:0]            side_ff;

   // Subtract the shifted divisor where it fits and set this quotient bit.
   always_comb begin
      logic [CW-1:0] dsh;
      logic [CW-1:0] rext;
      for (int l = 0; l < LANES; l++) begin
         dsh  = CW'(in_den[l]) << SHIFT;
         rext = CW'(in_rem[l]);
         if (rext >= dsh) begin
            rem_in[l] = NW'(rext - dsh);
            quo_in[l] = in_quo[l] | (QW'(1) << SHIFT);
         end else begin
            rem_in[l] = in_rem[l];
            quo_in[l] = in_quo[l];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
      if (adv) begin
         rem_ff  <= rem_in;
         den_ff  <= in_den;
         quo_ff  <= quo_in;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_den   = den_ff;
   assign out_quo   = quo_ff;
   assign out_side  = side_ff;

endmodule

// File: hw/rtl/occ_div_chain.sv
// A row of occ_div_cell stages forming a pipelined multi-lane divider.
// Depends on occ_div_cell.
`timescale 1ns / 1ps
module occ_div_chain #(
   parameter int LANES = 1,
   parameter int NW    = 8,
   parameter int DW    = 8,
   parameter int QW    = 8,
   parameter int SW    = 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  logic                          in_valid,
   input  logic [LANES-1:0][NW-1:0]      in_num,
   input  logic [LANES-1:0][DW-1:0]      in_den,
   input  logic [SW-1:0]                 in_side,
   output logic                          out_valid,
   output logic [LANES-1:0][QW-1:0]      out_quo,
   output logic [LANES-1:0][NW-1:0]      out_rem,
   output logic [SW-1:0]                 out_side
);

   logic [QW:0]                      valid_w;
   logic [QW:0][LANES-1:0][NW-1:0]   rem_w;
   logic [QW:0][LANES-1:0][DW-1:0]   den_w;
   logic [QW:0][LANES-1:0][QW-1:0]   quo_w;
   logic [QW:0][SW-1:0]              side_w;

   assign valid_w[0] = in_valid;
   assign rem_w[0]   = in_num;
   assign den_w[0]   = in_den;
   assign quo_w[0]   = '0;
   assign side_w[0]  = in_side;

   // Each cell resolves one quotient bit, most significant first.
   for (genvar i = 0; i < QW; i++) begin : g_cell
      occ_div_cell #(
         .LANES(LANES), .NW(NW), .DW(DW), .QW(QW), .SW(SW), .SHIFT(QW - 1 - i)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .adv      (adv),
         .in_valid (valid_w[i]),
         .in_rem   (rem_w[i]),
         .in_den   (den_w[i]),
         .in_quo   (quo_w[i]),
         .in_side  (side_w[i]),
         .out_valid(valid_w[i+1]),
         .out_rem  (rem_w[i+1]),
         .out_den  (den_w[i+1]),
         .out_quo  (quo_w[i+1]),
         .out_side (side_w[i+1])
      );
   end

   assign out_valid = valid_w[QW];
   assign out_quo   = quo_w[QW];
   assign out_rem   = rem_w[QW];
   assign out_side  = side_w[QW];

endmodule

// File: hw/rtl/gpu_occupancy_calculator.sv
// Stages from an accepted request to its response: 1 input stage, 23 cells
// of the rounding divider, 2 rounding stages, 7 cells of the limit divider,
// 1 minimum stage, 1 output register. Throughput: one transfer per cycle
// unless a response waits under rsp_stall, the only hold on the whole pipeline.
// Reset is synchronous: it empties the pipeline and loads configuration defaults.
`timescale 1ns / 1ps
module gpu_occupancy_calculator
   import occ_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [2:0]            csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [ITEMS_W-1:0]    req_items_per_group,
   input  logic [REGS_W-1:0]     req_registers_per_item,
   input  logic [LOCAL_W-1:0]    req_local_bytes_per_group,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [GROUPS_W-1:0]   rsp_groups_per_unit,
   output logic [WPG_W-1:0]      rsp_waves_per_group,
   output logic [WPU_W-1:0]      rsp_waves_per_unit
);

   // Configuration registers.
   logic [7:0]  wfs_ff;
   logic [6:0]  maxw_ff;
   logic [6:0]  cap_ff;
   logic        mode_ff;
   logic [10:0] ras_ff;
   logic [16:0] rfs_ff;
   logic [16:0] lma_ff;
   logic [20:0] lmt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wfs_ff  <= 8'd64;
         maxw_ff <= 7'd32;
         cap_ff  <= 7'd8;
         mode_ff <= 1'b1;
         ras_ff  <= 11'd32;
         rfs_ff  <= 17'd16384;
         lma_ff  <= 17'd1024;
         lmt_ff  <= 21'd32768;
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_WAVEFRONT_SIZE:  wfs_ff  <= csr_wdata[7:0];
            CSR_MAX_WAVES:       maxw_ff <= csr_wdata[6:0];
            CSR_MAX_GROUPS:      cap_ff  <= csr_wdata[6:0];
            CSR_REG_GRAN_MODE:   mode_ff <= csr_wdata[0];
            CSR_REG_ALLOC_SIZE:  ras_ff  <= csr_wdata[10:0];
            CSR_REG_FILE_SIZE:   rfs_ff  <= csr_wdata[16:0];
            CSR_LMEM_ALLOC_SIZE: lma_ff  <= csr_wdata[16:0];
            CSR_LMEM_TOTAL:      lmt_ff  <= csr_wdata[20:0];
            default: ;
         endcase
      end
   end

   // Every stage moves together; the only hold comes from a stalled response.
   logic adv;
   logic rsp_valid_ff;
   assign adv       = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !adv;

   // Input stage: the two register products and the ceiling numerator.
   logic              s1_valid_ff;
   logic [P2_NW-1:0]  s1_wnum_ff;
   p2_side_type       s1_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= req_valid;
      end
      if (adv) begin
         s1_wnum_ff         <= P2_NW'(req_items_per_group) + P2_NW'(wfs_ff) - P2_NW'(1);
         s1_side_ff.pw      <= 17'({8'd0, req_registers_per_item} * {9'd0, wfs_ff});
         s1_side_ff.pi      <= 23'({9'd0, req_items_per_group} *
                                   {14'd0, req_registers_per_item});
         s1_side_ff.local_b <= req_local_bytes_per_group;
         s1_side_ff.wz      <= (wfs_ff == 8'd0);
      end
   end

   // First divider row: wave count and the remainders needed for rounding up.
   logic [P2_LANES-1:0][P2_NW-1:0] c2_num;
   logic [P2_LANES-1:0][P2_DW-1:0] c2_den;
   logic                           c2_valid;
   logic [P2_LANES-1:0][P2_QW-1:0] c2_quo;
   logic [P2_LANES-1:0][P2_NW-1:0] c2_rem;
   logic [$bits(p2_side_type)-1:0] c2_side_bits;
   p2_side_type                    c2_side;

   always_comb begin
      c2_num[L2_WAVES] = s1_wnum_ff;
      c2_num[L2_PW]    = P2_NW'(s1_side_ff.pw);
      c2_num[L2_PI]    = s1_side_ff.pi;
      c2_num[L2_LOCAL] = P2_NW'(s1_side_ff.local_b);
      c2_den[L2_WAVES] = P2_DW'(wfs_ff);
      c2_den[L2_PW]    = P2_DW'(ras_ff);
      c2_den[L2_PI]    = P2_DW'(ras_ff);
      c2_den[L2_LOCAL] = lma_ff;
   end

   occ_div_chain #(
      .LANES(P2_LANES), .NW(P2_NW), .DW(P2_DW), .QW(P2_QW), .SW($bits(p2_side_type))
   ) u_round_div (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_valid (s1_valid_ff),
      .in_num   (c2_num),
      .in_den   (c2_den),
      .in_side  (s1_side_ff),
      .out_valid(c2_valid),
      .out_quo  (c2_quo),
      .out_rem  (c2_rem),
      .out_side (c2_side_bits)
   );
   assign c2_side = p2_side_type'(c2_side_bits);

   // Rounding stage: add the missing part of an allocation unit where a
   // remainder is left. A zero allocation unit means no rounding at all.
   logic              s3_valid_ff;
   logic [WPG_W-1:0]  s3_waves_ff;
   logic [17:0]       s3_rp1_ff;
   logic [23:0]       s3_rp2_ff;
   logic [21:0]       s3_lg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (adv) begin
         s3_valid_ff <= c2_valid;
      end
      if (adv) begin
         s3_waves_ff <= c2_side.wz ? '0 : c2_quo[L2_WAVES][WPG_W-1:0];
         if (ras_ff == 11'd0 || c2_rem[L2_PW][10:0] == 11'd0) begin
            s3_rp1_ff <= 18'(c2_side.pw);
         end else begin
            s3_rp1_ff <= 18'(c2_side.pw) + 18'(ras_ff) - 18'(c2_rem[L2_PW][10:0]);
         end
         if (ras_ff == 11'd0 || c2_rem[L2_PI][10:0] == 11'd0) begin
            s3_rp2_ff <= 24'(c2_side.pi);
         end else begin
            s3_rp2_ff <= 24'(c2_side.pi) + 24'(ras_ff) - 24'(c2_rem[L2_PI][10:0]);
         end
         if (lma_ff == 17'd0 || c2_rem[L2_LOCAL][16:0] == 17'd0) begin
            s3_lg_ff <= 22'(c2_side.local_b);
         end else begin
            s3_lg_ff <= 22'(c2_side.local_b) + 22'(lma_ff) - 22'(c2_rem[L2_LOCAL][16:0]);
         end
      end
   end

   // Registers per group: per-wavefront rounding times waves, or per-group rounding.
   logic              s4_valid_ff;
   logic [WPG_W-1:0]  s4_waves_ff;
   logic [31:0]       s4_rg_ff;
   logic [21:0]       s4_lg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (adv) begin
         s4_valid_ff <= s3_valid_ff;
      end
      if (adv) begin
         s4_waves_ff <= s3_waves_ff;
         s4_rg_ff    <= mode_ff ? 32'({14'd0, s3_rp1_ff} * {18'd0, s3_waves_ff})
                                : 32'(s3_rp2_ff);
         s4_lg_ff    <= s3_lg_ff;
      end
   end

   // Second divider row. A limit only counts when its divisor is nonzero and
   // the quotient stays below 128; a larger quotient never beats the group cap.
   logic [P4_LANES-1:0][P4_NW-1:0] c4_num;
   logic [P4_LANES-1:0][P4_DW-1:0] c4_den;
   p4_side_type                    c4_in_side;
   logic                           c4_valid;
   logic [P4_LANES-1:0][P4_QW-1:0] c4_quo;
   logic [P4_LANES-1:0][P4_NW-1:0] c4_rem;
   logic [$bits(p4_side_type)-1:0] c4_side_bits;
   p4_side_type                    c4_side;

   localparam int SATW = P4_NW + P4_DW + P4_QW;

   always_comb begin
      c4_num[L4_WAVE] = P4_NW'(maxw_ff);
      c4_num[L4_REG]  = P4_NW'(rfs_ff);
      c4_num[L4_LMEM] = lmt_ff;
      c4_den[L4_WAVE] = P4_DW'(s4_waves_ff);
      c4_den[L4_REG]  = s4_rg_ff;
      c4_den[L4_LMEM] = P4_DW'(s4_lg_ff);
      c4_in_side.waves = s4_waves_ff;
      for (int l = 0; l < P4_LANES; l++) begin
         c4_in_side.use_lim[l] = (c4_den[l] != '0) &&
            (SATW'(c4_num[l]) < (SATW'(c4_den[l]) << P4_QW));
      end
   end

   occ_div_chain #(
      .LANES(P4_LANES), .NW(P4_NW), .DW(P4_DW), .QW(P4_QW), .SW($bits(p4_side_type))
   ) u_limit_div (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_valid (s4_valid_ff),
      .in_num   (c4_num),
      .in_den   (c4_den),
      .in_side  (c4_in_side),
      .out_valid(c4_valid),
      .out_quo  (c4_quo),
      .out_rem  (c4_rem),
      .out_side (c4_side_bits)
   );
   assign c4_side = p4_side_type'(c4_side_bits);

   // Minimum of the cap and the limits that apply.
   logic                 s6_valid_ff;
   logic [GROUPS_W-1:0]  s6_groups_ff, s6_groups_in;
   logic [WPG_W-1:0]     s6_waves_ff;

   always_comb begin
      s6_groups_in = cap_ff;
      for (int l = 0; l < P4_LANES; l++) begin
         if (c4_side.use_lim[l] && (c4_quo[l] < s6_groups_in)) begin
            s6_groups_in = c4_quo[l];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_valid_ff <= 1'b0;
      end else if (adv) begin
         s6_valid_ff <= c4_valid;
      end
      if (adv) begin
         s6_groups_ff <= s6_groups_in;
         s6_waves_ff  <= c4_side.waves;
      end
   end

   // Output register: holds the response while the receiver stalls.
   logic [GROUPS_W-1:0] rsp_groups_ff;
   logic [WPG_W-1:0]    rsp_waves_ff;
   logic [WPU_W-1:0]    rsp_wpu_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= s6_valid_ff;
      end
      if (adv) begin
         rsp_groups_ff <= s6_groups_ff;
         rsp_waves_ff  <= s6_waves_ff;
         rsp_wpu_ff    <= WPU_W'({14'd0, s6_groups_ff} * {7'd0, s6_waves_ff});
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_groups_per_unit = rsp_groups_ff;
   assign rsp_waves_per_group = rsp_waves_ff;
   assign rsp_waves_per_unit  = rsp_wpu_ff;

`ifndef SYNTHESIS
   a_cap : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_groups_ff <= cap_ff)
      else $error("groups per unit exceeds the group cap");

   a_wave_slots : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_waves_ff != '0) |-> (21'(rsp_wpu_ff) <= 21'(maxw_ff)))
      else $error("waves per unit exceeds the wavefront slots");

   a_limit_path : assert property (@(posedge clock) disable iff (reset)
      (c4_valid && adv) |=> s6_valid_ff)
      else $error("a limit result was lost before the minimum stage");

   a_hold : assert property (@(posedge clock) disable iff (reset)
      !adv |=> (s6_valid_ff == $past(s6_valid_ff)))
      else $error("pipeline moved while the response was held");
`endif

endmodule
